/* src/assert_macros.svh */
// assertion helpers shared by the rtl files
// no dependencies; pulled in by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge, quiet while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/alle_pkg.sv */
// shared types and codes for the array linked list engine
// no dependencies; used by array_linked_list_engine
`timescale 1ns / 1ps

package alle_pkg;

  // default sizes
  localparam int SLOTS_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;

  // fixed field widths of the word ports
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_LIVE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SENTINEL = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_COMMIT,
    S_RESP
  } state_t;

endpackage

/* src/array_linked_list_engine.sv */
// Doubly linked list kept in slot memories, with a free chain and a sentinel slot.
// Input word: kind (insert after / delete / read), slot, value. Output word: status,
// result slot, its value and links, head, tail and live count after the step.
// Both channels are valid/ready; a word moves when valid and ready are high at an edge.
// Per item, the accept edge reads the link and value memories, the decide state
// decides and writes the first links, the commit state writes the remaining links and
// loads the output register if free. A single write port per link memory sets the split.
// in_ready is high whenever the sequencer is idle, also while a result still waits in
// the output register. If out_ready stays low, a finished result is held internally
// and the sequencer waits until the output register is free; no word is dropped.
// After reset a clearing pass over every slot initialises the link memories (free chain
// i to i+1, all previous links zero, no slot live); in_ready stays low during it.
// The value memory is not cleared; only live slots ever expose their value.
// Refused items (not live, list full, sentinel delete) change nothing.
// Depends on alle_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module array_linked_list_engine #(
  parameter int SLOTS      = alle_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = alle_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [alle_pkg::KIND_W-1:0]         in_kind,
  input  logic [alle_pkg::SLOT_W-1:0]         in_slot,
  input  logic signed [alle_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [alle_pkg::STATUS_W-1:0]       out_status,
  output logic [alle_pkg::SLOT_W-1:0]         out_result_slot,
  output logic signed [alle_pkg::DATA_W-1:0]  out_slot_value,
  output logic [alle_pkg::SLOT_W-1:0]         out_next_slot,
  output logic [alle_pkg::SLOT_W-1:0]         out_prev_slot,
  output logic [alle_pkg::SLOT_W-1:0]         out_head_slot,
  output logic [alle_pkg::SLOT_W-1:0]         out_tail_slot,
  output logic [alle_pkg::SLOT_W-1:0]         out_live_count
);

`include "assert_macros.svh"

  localparam int IW = $clog2(SLOTS);
  localparam int CW = (IW + 1 > alle_pkg::SLOT_W) ? IW + 1 : alle_pkg::SLOT_W;
  localparam int VB = VALUE_BITS;

  // memories: next word carries the live mark in its top bit
  logic [IW:0]          next_mem [SLOTS];
  logic [IW-1:0]        prev_mem [SLOTS];
  logic signed [VB-1:0] val_mem  [SLOTS];

  alle_pkg::state_t state_r, state_nxt;

  // item held while it is worked on
  logic [alle_pkg::KIND_W-1:0]        item_kind_r;
  logic [alle_pkg::SLOT_W-1:0]        item_slot_r;
  logic signed [alle_pkg::DATA_W-1:0] item_value_r;

  // list registers; the sentinel's links live here rather than in memory
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic [IW-1:0] init_idx_r;

  // registered memory reads
  logic [IW:0]          rd_next_a_r;
  logic [IW-1:0]        rd_next_b_r;
  logic [IW-1:0]        rd_prev_a_r;
  logic signed [VB-1:0] rd_val_r;

  // second round of link writes, prepared in the decide cycle
  logic          w2_next_en_r, w2_next_en_nxt;
  logic [IW-1:0] w2_next_addr_r, w2_next_addr_nxt;
  logic [IW:0]   w2_next_data_r, w2_next_data_nxt;
  logic          w2_prev_en_r, w2_prev_en_nxt;
  logic [IW-1:0] w2_prev_addr_r, w2_prev_addr_nxt;
  logic [IW-1:0] w2_prev_data_r, w2_prev_data_nxt;

  // result held until the output register is free
  logic [alle_pkg::STATUS_W-1:0]      res_status_r, res_status_nxt;
  logic [alle_pkg::SLOT_W-1:0]        res_slot_r, res_slot_nxt;
  logic signed [alle_pkg::DATA_W-1:0] res_value_r, res_value_nxt;
  logic [alle_pkg::SLOT_W-1:0]        res_next_r, res_next_nxt;
  logic [alle_pkg::SLOT_W-1:0]        res_prev_r, res_prev_nxt;

  // output register
  logic                               out_valid_r;
  logic [alle_pkg::STATUS_W-1:0]      out_status_r;
  logic [alle_pkg::SLOT_W-1:0]        out_slot_r;
  logic signed [alle_pkg::DATA_W-1:0] out_value_r;
  logic [alle_pkg::SLOT_W-1:0]        out_next_r;
  logic [alle_pkg::SLOT_W-1:0]        out_prev_r;
  logic [alle_pkg::SLOT_W-1:0]        out_head_r;
  logic [alle_pkg::SLOT_W-1:0]        out_tail_r;
  logic [alle_pkg::SLOT_W-1:0]        out_count_r;

  // memory write ports
  logic          next_we;
  logic [IW-1:0] next_waddr;
  logic [IW:0]   next_wdata;
  logic          prev_we;
  logic [IW-1:0] prev_waddr;
  logic [IW-1:0] prev_wdata;
  logic          val_we;

  // decoded item
  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  logic [IW-1:0]        slot_i;
  logic                 slot_zero;
  logic                 slot_live;
  logic [IW-1:0]        succ;
  logic signed [VB-1:0] val_in_s;
  logic                 init_last;
  logic [IW:0]          init_word;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == alle_pkg::S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = ((state_r == alle_pkg::S_COMMIT) || (state_r == alle_pkg::S_RESP))
                     && out_free;

  assign slot_i    = IW'(item_slot_r);
  assign slot_zero = (item_slot_r == '0);
  assign slot_live = slot_zero ||
                     ((CW'(item_slot_r) < CW'(SLOTS)) && rd_next_a_r[IW]);
  assign succ      = slot_zero ? head_r : rd_next_a_r[IW-1:0];
  assign val_in_s  = VB'(item_value_r);

  // clearing pass contents
  assign init_last = (init_idx_r == IW'(SLOTS - 1));
  assign init_word = {1'b0, ((init_idx_r != '0) && !init_last) ? init_idx_r + 1'b1 : '0};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alle_pkg::S_INIT:   if (init_last) state_nxt = alle_pkg::S_IDLE;
      alle_pkg::S_IDLE:   if (accept) state_nxt = alle_pkg::S_EXEC;
      alle_pkg::S_EXEC:   state_nxt = alle_pkg::S_COMMIT;
      alle_pkg::S_COMMIT: state_nxt = out_free ? alle_pkg::S_IDLE : alle_pkg::S_RESP;
      alle_pkg::S_RESP:   if (out_free) state_nxt = alle_pkg::S_IDLE;
      default:            state_nxt = alle_pkg::S_INIT;
    endcase
  end

  // decide cycle: status, list registers, result and the second write round
  always_comb begin
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    free_nxt         = free_r;
    count_nxt        = count_r;
    w2_next_en_nxt   = 1'b0;
    w2_next_addr_nxt = w2_next_addr_r;
    w2_next_data_nxt = w2_next_data_r;
    w2_prev_en_nxt   = 1'b0;
    w2_prev_addr_nxt = w2_prev_addr_r;
    w2_prev_data_nxt = w2_prev_data_r;
    res_status_nxt   = res_status_r;
    res_slot_nxt     = res_slot_r;
    res_value_nxt    = res_value_r;
    res_next_nxt     = res_next_r;
    res_prev_nxt     = res_prev_r;
    next_we          = 1'b0;
    next_waddr       = init_idx_r;
    next_wdata       = init_word;
    prev_we          = 1'b0;
    prev_waddr       = init_idx_r;
    prev_wdata       = '0;
    val_we           = 1'b0;

    unique case (state_r)
      alle_pkg::S_INIT: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      alle_pkg::S_EXEC: begin
        res_status_nxt = alle_pkg::ST_OK;
        res_slot_nxt   = item_slot_r;
        res_value_nxt  = '0;
        res_next_nxt   = '0;
        res_prev_nxt   = '0;
        unique case (item_kind_r)
          // insert after the target slot, taking the free chain's head
          alle_pkg::KIND_INSERT: begin
            if (!slot_live) begin
              res_status_nxt = alle_pkg::ST_NOT_LIVE;
            end else if (free_r == '0) begin
              res_status_nxt = alle_pkg::ST_FULL;
            end else begin
              next_we    = 1'b1;
              next_waddr = free_r;
              next_wdata = {1'b1, succ};
              prev_we    = 1'b1;
              prev_waddr = free_r;
              prev_wdata = slot_i;
              val_we     = 1'b1;
              free_nxt   = rd_next_b_r;
              count_nxt  = count_r + 1'b1;
              if (slot_zero) begin
                head_nxt = free_r;
              end else begin
                w2_next_en_nxt   = 1'b1;
                w2_next_addr_nxt = slot_i;
                w2_next_data_nxt = {1'b1, free_r};
              end
              if (succ == '0) begin
                tail_nxt = free_r;
              end else begin
                w2_prev_en_nxt   = 1'b1;
                w2_prev_addr_nxt = succ;
                w2_prev_data_nxt = free_r;
              end
              res_slot_nxt  = alle_pkg::SLOT_W'(free_r);
              res_value_nxt = alle_pkg::DATA_W'(val_in_s);
              res_next_nxt  = alle_pkg::SLOT_W'(succ);
              res_prev_nxt  = item_slot_r;
            end
          end
          // unlink the target and push it on the free chain
          alle_pkg::KIND_DELETE: begin
            if (slot_zero) begin
              res_status_nxt = alle_pkg::ST_SENTINEL;
            end else if (!slot_live) begin
              res_status_nxt = alle_pkg::ST_NOT_LIVE;
            end else begin
              if (rd_prev_a_r == '0) begin
                head_nxt = rd_next_a_r[IW-1:0];
              end else begin
                next_we    = 1'b1;
                next_waddr = rd_prev_a_r;
                next_wdata = {1'b1, rd_next_a_r[IW-1:0]};
              end
              if (rd_next_a_r[IW-1:0] == '0) begin
                tail_nxt = rd_prev_a_r;
              end else begin
                prev_we    = 1'b1;
                prev_waddr = rd_next_a_r[IW-1:0];
                prev_wdata = rd_prev_a_r;
              end
              w2_next_en_nxt   = 1'b1;
              w2_next_addr_nxt = slot_i;
              w2_next_data_nxt = {1'b0, free_r};
              w2_prev_en_nxt   = 1'b1;
              w2_prev_addr_nxt = slot_i;
              w2_prev_data_nxt = '0;
              free_nxt         = slot_i;
              count_nxt        = count_r - 1'b1;
              res_value_nxt    = alle_pkg::DATA_W'(rd_val_r);
              res_next_nxt     = alle_pkg::SLOT_W'(rd_next_a_r[IW-1:0]);
              res_prev_nxt     = alle_pkg::SLOT_W'(rd_prev_a_r);
            end
          end
          // read, the unused kind included
          default: begin
            if (!slot_live) begin
              res_status_nxt = alle_pkg::ST_NOT_LIVE;
            end else if (slot_zero) begin
              res_next_nxt = alle_pkg::SLOT_W'(head_r);
              res_prev_nxt = alle_pkg::SLOT_W'(tail_r);
            end else begin
              res_value_nxt = alle_pkg::DATA_W'(rd_val_r);
              res_next_nxt  = alle_pkg::SLOT_W'(rd_next_a_r[IW-1:0]);
              res_prev_nxt  = alle_pkg::SLOT_W'(rd_prev_a_r);
            end
          end
        endcase
      end
      alle_pkg::S_COMMIT: begin
        next_we    = w2_next_en_r;
        next_waddr = w2_next_addr_r;
        next_wdata = w2_next_data_r;
        prev_we    = w2_prev_en_r;
        prev_waddr = w2_prev_addr_r;
        prev_wdata = w2_prev_data_r;
      end
      default: begin
      end
    endcase
  end

  // link and value memories
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    if (val_we)  val_mem[free_r]      <= val_in_s;
    rd_next_a_r <= next_mem[IW'(in_slot)];
    rd_next_b_r <= next_mem[free_r][IW-1:0];
    rd_prev_a_r <= prev_mem[IW'(in_slot)];
    rd_val_r    <= val_mem[IW'(in_slot)];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= alle_pkg::S_INIT;
      init_idx_r   <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      free_r       <= IW'(1);
      count_r      <= '0;
      w2_next_en_r <= 1'b0;
      w2_prev_en_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (state_r == alle_pkg::S_INIT) init_idx_r <= init_idx_r + 1'b1;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      free_r       <= free_nxt;
      count_r      <= count_nxt;
      if (state_r == alle_pkg::S_EXEC) begin
        w2_next_en_r <= w2_next_en_nxt;
        w2_prev_en_r <= w2_prev_en_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind_r  <= in_kind;
      item_slot_r  <= in_slot;
      item_value_r <= in_value;
    end
    w2_next_addr_r <= w2_next_addr_nxt;
    w2_next_data_r <= w2_next_data_nxt;
    w2_prev_addr_r <= w2_prev_addr_nxt;
    w2_prev_data_r <= w2_prev_data_nxt;
    res_status_r   <= res_status_nxt;
    res_slot_r     <= res_slot_nxt;
    res_value_r    <= res_value_nxt;
    res_next_r     <= res_next_nxt;
    res_prev_r     <= res_prev_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_value_r  <= res_value_r;
      out_next_r   <= res_next_r;
      out_prev_r   <= res_prev_r;
      out_head_r   <= alle_pkg::SLOT_W'(head_r);
      out_tail_r   <= alle_pkg::SLOT_W'(tail_r);
      out_count_r  <= alle_pkg::SLOT_W'(count_r);
    end
  end

  // result word
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_slot = out_slot_r;
  assign out_slot_value  = out_value_r;
  assign out_next_slot   = out_next_r;
  assign out_prev_slot   = out_prev_r;
  assign out_head_slot   = out_head_r;
  assign out_tail_slot   = out_tail_r;
  assign out_live_count  = out_count_r;

  // checks
  `ASSERT_CLK(a_accept_to_exec, clk, rst_n,
    accept |=> (state_r == alle_pkg::S_EXEC), "accepted word did not start decoding")
  `ASSERT_CLK(a_full_count, clk, rst_n,
    (free_r == '0) |-> (count_r == IW'(SLOTS - 1)), "free chain empty but list not full")
  `ASSERT_CLK(a_empty_ends, clk, rst_n,
    ((head_r == '0) == (count_r == '0)) && ((tail_r == '0) == (count_r == '0)),
    "head or tail disagrees with live count")
  `ASSERT_CLK(a_out_source, clk, rst_n,
    $rose(out_valid_r) |->
      ($past(state_r) == alle_pkg::S_COMMIT) || ($past(state_r) == alle_pkg::S_RESP),
    "result word raised outside the hand-off states")

endmodule
